@@ rtl/pscc_pkg.sv @@
// Shared types, widths and codes of the clamped PID speed controller.
package pscc_pkg;

    // Fixed field and register widths
    localparam int SPEED_W    = 16;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 8;
    localparam int DUTY_W     = 8;
    localparam int INTEG_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Derived datapath widths
    localparam int ERR_W  = SPEED_W + 1;           // signed speed difference
    localparam int P_W    = ERR_W + GAIN_W + 1;    // signed proportional term
    localparam int KI_W   = GAIN_W + DT_W;         // gain_i * time_step
    localparam int NUM_W  = GAIN_W + SPEED_W;      // gain_d * |delta|
    localparam int PROD_W = SPEED_W + KI_W;        // |error| * gain_i * time_step
    localparam int U_W    = 64;                    // controller sum
    localparam int D_SAT_SHIFT = 60;               // derivative magnitude limit 2^60

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET     = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_DUTY_LIMIT = 3'd4
    } cfg_reg_t;

    // Clamp status codes
    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_ZERO = 2'd2
    } clamp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_IMUL,
        ST_IACC,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input word
        logic mul;       // form P, gain_i*dt and gain_d*|delta|
        logic imul;      // integral product, start the divider
        logic iacc;      // saturating integral update
        logic sum;       // form u
        logic out_load;  // clamp into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

@@ rtl/pscc_div.sv @@
// Radix-2 restoring divider, two quotient bits per cycle, for the derivative term.
module pscc_div
    import pscc_pkg::*;
#(
    parameter int DIV_BITS = 56
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [DT_W-1:0]     divisor,
    output logic                busy,
    output logic [DIV_BITS-1:0] quotient
);

    localparam int STEPS = DIV_BITS / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [DT_W-1:0]     rem_reg, rem_next;
    logic [DT_W-1:0]     dsr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;

    logic [DT_W:0]   t1, t2;
    logic            q1, q2;
    logic [DT_W-1:0] r1;

    // Two dependent subtract steps on the narrow remainder
    always_comb
    begin
        t1 = {rem_reg, dvd_reg[DIV_BITS-1]};
        q1 = (t1 >= {1'b0, dsr_reg});
        r1 = q1 ? DT_W'(t1 - {1'b0, dsr_reg}) : t1[DT_W-1:0];
        t2 = {r1, dvd_reg[DIV_BITS-2]};
        q2 = (t2 >= {1'b0, dsr_reg});
        rem_next = q2 ? DT_W'(t2 - {1'b0, dsr_reg}) : t2[DT_W-1:0];
        dvd_next = {dvd_reg[DIV_BITS-3:0], q1, q2};
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Dividend shifts out, quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

@@ rtl/pscc_datapath.sv @@
// Datapath: configuration registers, PID state, multipliers, divider and clamp.
module pscc_datapath
    import pscc_pkg::*;
#(
    parameter int SPEED_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SPEED_W-1:0]    in_meas,
    input  logic [DT_W-1:0]       in_dt,
    input  logic                  in_clr,
    output logic [DUTY_W-1:0]     duty,
    output logic [1:0]            clamp_state
);

    localparam int QUO_RAW_W = NUM_W + FRAC_BITS;
    localparam int DIV_BITS  = QUO_RAW_W + (QUO_RAW_W % 2);
    localparam int ACC_W     = INTEG_W + 1;
    localparam int QX_W      = 65;
    localparam int DMAG_W    = D_SAT_SHIFT + 1;
    localparam logic [SPEED_W-1:0] SPEED_MASK = (SPEED_BITS >= SPEED_W) ? {SPEED_W{1'b1}}
                                              : SPEED_W'((32'd1 << SPEED_BITS) - 32'd1);

    // Configuration registers
    logic [SPEED_W-1:0] target_reg;
    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // PID state
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [SPEED_W-1:0]        prev_reg;

    // Per-item working registers
    logic [SPEED_W-1:0]    meas_reg;
    logic [DT_W-1:0]       dt_reg;
    logic                  clr_reg;
    logic signed [P_W-1:0] p_reg, p_next;
    logic [KI_W-1:0]       k_reg, k_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [SPEED_W-1:0]    err_mag_reg;
    logic                  err_neg_reg, delta_neg_reg;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [U_W-1:0]        u_reg, u_next;
    logic [DUTY_W-1:0]     duty_reg;
    logic [1:0]            clamp_reg;

    logic [SPEED_W-1:0]       meas_m, tgt_m, err_mag, delta_mag;
    logic signed [ERR_W-1:0]  err, delta;
    logic signed [GAIN_W:0]   gain_p_s;

    logic [PROD_W-1:0]        prod_sh;
    logic [INTEG_W-1:0]       mag_i, mag_pos;
    logic signed [ACC_W-1:0]  inc, acc;
    logic signed [INTEG_W-1:0] base;

    logic [DIV_BITS-1:0] dividend, quotient;
    logic                div_busy;
    logic [QX_W-1:0]     quo_x;
    logic [DMAG_W-1:0]   dmag;
    logic [U_W-1:0]      dterm_add, p_x, i_x, top;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:     target_reg <= cfg_data[SPEED_W-1:0];
                REG_GAIN_P:     gain_p_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg <= cfg_data[GAIN_W-1:0];
                REG_DUTY_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Error, speed change, the three first-stage products and the integral product
    always_comb
    begin
        meas_m    = meas_reg & SPEED_MASK;
        tgt_m     = target_reg & SPEED_MASK;
        err       = $signed({1'b0, tgt_m}) - $signed({1'b0, meas_m});
        delta     = $signed({1'b0, meas_m}) - $signed({1'b0, prev_reg});
        err_mag   = err[ERR_W-1] ? SPEED_W'(-err) : err[SPEED_W-1:0];
        delta_mag = delta[ERR_W-1] ? SPEED_W'(-delta) : delta[SPEED_W-1:0];
        gain_p_s  = $signed({1'b0, gain_p_reg});
        p_next    = err * gain_p_s;
        k_next    = gain_i_reg * dt_reg;
        num_next  = gain_d_reg * delta_mag;
        prod_next = err_mag_reg * k_reg;
    end

    // Integral increment, truncated toward zero, then saturating add
    always_comb
    begin
        prod_sh = prod_reg >> FRAC_BITS;
        mag_i   = (|prod_sh[PROD_W-1:INTEG_W-1]) ? (INTEG_W'(1) << (INTEG_W - 1))
                                                 : prod_sh[INTEG_W-1:0];
        mag_pos = mag_i[INTEG_W-1] ? {1'b0, {(INTEG_W-1){1'b1}}} : mag_i;
        inc     = err_neg_reg ? -$signed({1'b0, mag_i}) : $signed({1'b0, mag_pos});
        base    = clr_reg ? '0 : integ_reg;
        acc     = $signed({base[INTEG_W-1], base}) + inc;
        if (acc[ACC_W-1] != acc[INTEG_W-1])
        begin
            integ_next = acc[ACC_W-1] ? $signed({1'b1, {(INTEG_W-1){1'b0}}})
                                      : $signed({1'b0, {(INTEG_W-1){1'b1}}});
        end
        else
        begin
            integ_next = acc[INTEG_W-1:0];
        end
    end

    // Derivative magnitude with saturation, and the controller sum
    always_comb
    begin
        dividend  = DIV_BITS'({num_reg, {FRAC_BITS{1'b0}}});
        quo_x     = QX_W'(quotient);
        dmag      = (quo_x >= (QX_W'(1) << D_SAT_SHIFT)) ? (DMAG_W'(1) << D_SAT_SHIFT)
                                                         : quo_x[DMAG_W-1:0];
        dterm_add = delta_neg_reg ? U_W'(dmag) : U_W'(-U_W'(dmag));
        p_x       = {{(U_W-P_W){p_reg[P_W-1]}}, p_reg};
        i_x       = {{(U_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
        u_next    = p_x + i_x + dterm_add;
        top       = U_W'(limit_reg) << FRAC_BITS;
    end

    // PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cmd.mul)
            begin
                prev_reg <= meas_m;
            end
            if (cmd.iacc)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= in_meas;
            dt_reg   <= (in_dt == '0) ? DT_W'(1) : in_dt;
            clr_reg  <= in_clr;
        end
        if (cmd.mul)
        begin
            p_reg         <= p_next;
            k_reg         <= k_next;
            num_reg       <= num_next;
            err_mag_reg   <= err_mag;
            err_neg_reg   <= err[ERR_W-1];
            delta_neg_reg <= delta[ERR_W-1];
        end
        if (cmd.imul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.sum)
        begin
            u_reg <= u_next;
        end
        if (cmd.out_load)
        begin
            if ($signed(u_reg) > $signed(top))
            begin
                duty_reg  <= limit_reg;
                clamp_reg <= CLAMP_HIGH;
            end
            else if (u_reg[U_W-1])
            begin
                duty_reg  <= '0;
                clamp_reg <= CLAMP_ZERO;
            end
            else
            begin
                duty_reg  <= u_reg[FRAC_BITS +: DUTY_W];
                clamp_reg <= CLAMP_NONE;
            end
        end
    end

    // Divider for gain_d*|delta|*2^F / time_step
    pscc_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.imul),
        .dividend (dividend),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.div_busy = div_busy;
    assign duty            = duty_reg;
    assign clamp_state     = clamp_reg;

endmodule

@@ rtl/pscc_ctrl.sv @@
// Controller: sequences one word through the datapath and owns the output valid.
module pscc_ctrl
    import pscc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.imul   = 1'b1;
                state_next = ST_IACC;
            end
            ST_IACC:
            begin
                cmd.iacc   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/pid_speed_controller_clamped.sv @@
// Top level of the clamped PID speed controller with derivative on measurement.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser: each carries a
//   measured speed, a time step (Q0.F seconds, zero taken as one LSB) and a
//   flag that clears the integral before the step. Every word yields exactly
//   one result word on m_tvalid/m_tready/m_tdata/m_tuser: the PWM duty and the
//   clamp status. Registers are written through cfg_we/cfg_index/cfg_data
//   while no word is in flight, which the user must keep to and the block does
//   not enforce; index 0 target speed, 1..3 gains P/I/D, 4 duty limit.
// Sequence:
//   An accepted word passes through the states MUL, IMUL, IACC, DIV, SUM and
//   OUT before the next acceptance. The derivative divider, with DIV_BITS =
//   40 + FRAC_BITS rounded up to even and two quotient bits per cycle, sets
//   the length of DIV; the result appears when OUT loads the output register.
// Reset and stall:
//   Reset clears the integral, the previous speed, the gains and target, and
//   sets the duty limit to 255. A stalled receiver holds the result in the
//   output register; the next word is still taken and computed, and waits
//   for that register before it is delivered.
module pid_speed_controller_clamped
    import pscc_pkg::*;
#(
    parameter int SPEED_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] measured_speed, [31:16] time_step
    input  logic [0:0]            s_tuser,   // [0] clear_integral
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] duty
    output logic [1:0]            m_tuser,   // [1:0] clamp_state
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pscc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pscc_datapath #(
        .SPEED_BITS (SPEED_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_meas     (s_tdata[15:0]),
        .in_dt       (s_tdata[31:16]),
        .in_clr      (s_tuser[0]),
        .duty        (m_tdata),
        .clamp_state (m_tuser)
    );

    // One word in flight: an accepted word closes the input until it is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // Clamped at zero always reports a zero duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == CLAMP_ZERO)) |-> (m_tdata == '0))
        else $error("zero clamp with nonzero duty");

    // A new result only comes out of a word that was being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

endmodule
